### sv/ifs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ifs_pkg: shared types and constants of the isolation forest scorer
// Holds the commands, the configuration register map and the 2^-x table.
// ----------------------------------------------------------------------------
package ifs_pkg;

    localparam int NODE_DEPTH_DEF   = 32768;
    localparam int MAX_TREES_DEF    = 64;
    localparam int MAX_FEATURES_DEF = 32;
    localparam int DEPTH_GUARD_DEF  = 16;

    localparam logic [1:0] CMD_NODE = 2'd0;
    localparam logic [1:0] CMD_ROOT = 2'd1;
    localparam logic [1:0] CMD_FEAT = 2'd2;
    localparam logic [1:0] CMD_RSVD = 2'd3;

    localparam logic [1:0] REG_TREE_COUNT = 2'd0;
    localparam logic [1:0] REG_NODE_COUNT = 2'd1;
    localparam logic [1:0] REG_FEAT_TOTAL = 2'd2;
    localparam logic [1:0] REG_PATH_SCALE = 2'd3;

    // one node record as read from the node memory
    typedef struct packed {
        logic [4:0]  feat;
        logic        leaf;
        logic [31:0] split;
        logic [14:0] left;
        logic [14:0] right;
        logic [23:0] adj;
    } t_node;

    // start and finish between the walker and the top level
    typedef struct packed {
        logic        start;
        logic        done;
        logic [34:0] sum;
    } t_walk_ctl;

    // floor of the square root, bit by bit
    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] b;
        v   = v_in;
        res = '0;
        b   = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v   = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // round(2^16 * 2^(-i/256)) for i = 0..255, 17 bits per entry, entry i at
    // bits [i*17 +: 17]; built from repeated square roots of one half
    function automatic logic [256*17-1:0] exp_table();
        logic [63:0]       f [8];
        logic [127:0]      p;
        logic [256*17-1:0] t;
        t    = '0;
        f[7] = isqrt64(64'h8000_0000 << 32);
        for (int k = 6; k >= 0; k--) f[k] = isqrt64(f[k + 1] << 32);
        for (int i = 0; i < 256; i++) begin
            p = 128'd1 << 32;
            for (int k = 7; k >= 0; k--)
                if (i[k]) p = (p * 128'(f[k]) + 128'h8000_0000) >> 32;
            t[i*17 +: 17] = 17'((p + 128'h8000) >> 16);
        end
        return t;
    endfunction

endpackage
`default_nettype wire

### sv/ifs_walker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ifs_walker: tree walk sequencer
// Walks every tree in use through the node memory, one inner node at a
// time (S_NODE, S_NODEW, S_FEATW), and accumulates depth plus leaf adjustment
// over the forest.
module ifs_walker #(
    parameter int NODE_DEPTH   = ifs_pkg::NODE_DEPTH_DEF,
    parameter int MAX_TREES    = ifs_pkg::MAX_TREES_DEF,
    parameter int MAX_FEATURES = ifs_pkg::MAX_FEATURES_DEF,
    parameter int DEPTH_GUARD  = ifs_pkg::DEPTH_GUARD_DEF
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_start,
    input  wire  [6:0]                         i_tree_count,
    input  wire  [15:0]                        i_node_count,
    input  wire  [5:0]                         i_feat_total,
    // node, root and feature memory write ports
    input  wire                                i_node_we,
    input  wire  [$clog2(NODE_DEPTH)-1:0]      i_node_waddr,
    input  wire  ifs_pkg::t_node               i_node_wdata,
    input  wire                                i_root_we,
    input  wire  [((MAX_TREES > 1) ? $clog2(MAX_TREES) : 1)-1:0]       i_root_waddr,
    input  wire  [14:0]                        i_root_wdata,
    input  wire                                i_feat_we,
    input  wire  [((MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1)-1:0] i_feat_waddr,
    input  wire  [31:0]                        i_feat_wdata,
    output logic                               o_done,
    output logic [34:0]                        o_sum
);
    localparam int NAW = $clog2(NODE_DEPTH);
    localparam int TW  = $clog2(MAX_TREES + 1);
    localparam int TIW = (MAX_TREES > 1) ? $clog2(MAX_TREES) : 1;
    localparam int FIW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;

    typedef enum logic [2:0] {S_IDLE, S_ROOT, S_ROOTW, S_NODE, S_NODEW, S_FEATW}
        t_state;

    ifs_pkg::t_node r_node_mem [NODE_DEPTH];
    logic [14:0]    r_root_mem [MAX_TREES];
    logic [31:0]    r_feat_mem [MAX_FEATURES];

    ifs_pkg::t_node r_nd;
    logic [14:0]    r_root_q;
    logic [31:0]    r_feat_q;

    t_state       r_state;
    logic [TW-1:0] r_tree;
    logic [TW-1:0] r_trees;
    logic [15:0]  r_cur;
    logic [5:0]   r_depth;
    logic [34:0]  r_sum;
    logic         r_done;

    // read addresses come straight from the walk registers, data in the next cycle
    always_ff @(posedge i_clk) begin
        if (i_node_we) r_node_mem[i_node_waddr] <= i_node_wdata;
        if (i_root_we) r_root_mem[i_root_waddr] <= i_root_wdata;
        if (i_feat_we) r_feat_mem[i_feat_waddr] <= i_feat_wdata;
        r_nd     <= r_node_mem[r_cur[NAW-1:0]];
        r_root_q <= r_root_mem[r_tree[TIW-1:0]];
        r_feat_q <= r_feat_mem[FIW'(r_nd.feat)];
    end

    logic        w_oor;
    logic        w_feat_ok;
    logic        w_less;
    logic [15:0] w_next;
    always_comb begin
        w_oor     = (r_cur >= i_node_count) || (32'(r_cur) >= NODE_DEPTH);
        w_feat_ok = (6'(r_nd.feat) < i_feat_total) && (32'(r_nd.feat) < MAX_FEATURES);
        w_less    = w_feat_ok && ($signed(r_feat_q) < $signed(r_nd.split));
        w_next    = {1'b0, w_less ? r_nd.left : r_nd.right};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            r_tree  <= '0;
            r_trees <= '0;
        end else begin
            r_done <= (r_state == S_ROOT) && (r_tree == r_trees);
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_sum   <= '0;
                        r_tree  <= '0;
                        r_trees <= (32'(i_tree_count) > MAX_TREES) ? TW'(MAX_TREES)
                                                                   : TW'(i_tree_count);
                        r_state <= S_ROOT;
                    end
                end
                S_ROOT: begin
                    if (r_tree == r_trees) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_state <= S_ROOTW;
                    end
                end
                S_ROOTW: begin
                    r_cur   <= {1'b0, r_root_q};
                    r_depth <= '0;
                    r_state <= S_NODE;
                end
                S_NODE: begin
                    if (w_oor) begin
                        r_sum   <= r_sum + {13'd0, r_depth, 16'd0};
                        r_tree  <= r_tree + 1'b1;
                        r_state <= S_ROOT;
                    end else begin
                        r_state <= S_NODEW;
                    end
                end
                S_NODEW: begin
                    if (r_nd.leaf) begin
                        r_sum   <= r_sum + {13'd0, r_depth, 16'd0} + 35'(r_nd.adj);
                        r_tree  <= r_tree + 1'b1;
                        r_state <= S_ROOT;
                    end else if (32'(r_depth) >= DEPTH_GUARD) begin
                        r_sum   <= r_sum + {13'd0, r_depth, 16'd0};
                        r_tree  <= r_tree + 1'b1;
                        r_state <= S_ROOT;
                    end else begin
                        r_state <= S_FEATW;
                    end
                end
                S_FEATW: begin
                    r_cur   <= w_next;
                    r_depth <= r_depth + 1'b1;
                    r_state <= S_NODE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_sum  = r_sum;
endmodule
`default_nettype wire

### sv/ifs_score.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ifs_score: exponent and score stage
// Scales the path sum, saturates the exponent and looks up 2^-e, registered
// after the multiplier and after the table.
// ----------------------------------------------------------------------------
module ifs_score (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_go,
    input  wire  [34:0] i_sum,
    input  wire  [23:0] i_scale,
    output logic        o_valid,
    output logic [16:0] o_score,
    output logic [26:0] o_total
);
    localparam logic [256*17-1:0] EXP_TABLE = ifs_pkg::exp_table();

    // split the multiply into two partial products, registered in r_plo and then r_phi
    logic [1:0]  r_vld;
    logic [47:0] r_plo;
    logic [34:0] r_sum;
    logic [34:0] r_phi;

    logic [58:0] w_prod;
    logic [34:0] w_e;
    logic [23:0] w_es;
    logic [7:0]  w_ip;
    logic [16:0] w_rom;
    always_comb begin
        w_prod = 59'(r_plo) + {r_phi, 24'd0};
        w_e    = w_prod[58:24];
        w_es   = (w_e > 35'hFFFFFF) ? 24'hFFFFFF : w_e[23:0];
        w_ip   = w_es[23:16];
        w_rom  = EXP_TABLE[int'(w_es[15:8]) * 17 +: 17];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            o_valid <= 1'b0;
        end else begin
            r_vld   <= {r_vld[0], i_go};
            o_valid <= r_vld[1];
        end
        if (i_go) begin
            r_plo <= 48'(i_sum[23:0]) * 48'(i_scale);
            r_sum <= i_sum;
        end
        if (r_vld[0]) r_phi <= 35'(r_sum[34:24]) * 35'(i_scale);
        if (r_vld[1]) begin
            o_score <= (w_ip >= 8'd17) ? 17'd0 : (w_rom >> w_ip);
            o_total <= (r_sum > 35'h7FFFFFF) ? 27'h7FFFFFF : r_sum[26:0];
        end
    end
endmodule
`default_nettype wire

### sv/isolation_forest_scorer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// isolation_forest_scorer: isolation forest anomaly score
// Table loads, feature stream and one score per vector.
// ----------------------------------------------------------------------------
// Usage: write tree count, node count, feature total and path scale on the
// config channel while nothing is in flight. Load node records (cmd 0) and
// tree roots (cmd 1) on the input channel; each load or non-final feature
// (cmd 2) is one transfer and one cycle, so they can follow back to back.
// The feature marked final starts scoring and the input channel holds ready
// low until the result transfer completes.
// Scoring steps from the final transfer to o_valid: per tree a root read
// (S_ROOT, S_ROOTW), then per inner node passed a node read, a feature read
// and a step (S_NODE, S_NODEW, S_FEATW); a tree ends at a leaf or a node cut
// by the depth guard after the node read, or at an out-of-range node before
// it. Then come the end check, two multiply stages, the table stage and the
// output register. With tree count zero the zero result is valid in the
// cycle after the transfer.
// Reset clears the configuration registers and control state only; the
// memories hold garbage until written. A stalled receiver holds the result in
// the output register and the block takes no further item until it is moved.
// ----------------------------------------------------------------------------
module isolation_forest_scorer #(
    parameter int NODE_DEPTH   = ifs_pkg::NODE_DEPTH_DEF,
    parameter int MAX_TREES    = ifs_pkg::MAX_TREES_DEF,
    parameter int MAX_FEATURES = ifs_pkg::MAX_FEATURES_DEF,
    parameter int DEPTH_GUARD  = ifs_pkg::DEPTH_GUARD_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_ready,
    input  wire  [1:0]  i_cmd,
    input  wire  [14:0] i_slot,
    input  wire  [4:0]  i_split_sel,
    input  wire  [31:0] i_data_value,
    input  wire  [14:0] i_lo_link,
    input  wire  [14:0] i_hi_link,
    input  wire         i_leaf_flag,
    input  wire  [23:0] i_leaf_adjust,
    input  wire         i_final_element,
    output logic        o_valid,
    input  wire         i_ready,
    output logic [16:0] o_score,
    output logic [26:0] o_path_sum,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [1:0]  i_cfg_index,
    input  wire  [23:0] i_cfg_data
);
    localparam int NAW = $clog2(NODE_DEPTH);
    localparam int TIW = (MAX_TREES > 1) ? $clog2(MAX_TREES) : 1;
    localparam int FIW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;

    logic [6:0]  r_tree_count;
    logic [15:0] r_node_count;
    logic [5:0]  r_feat_total;
    logic [23:0] r_path_scale;
    logic        r_busy;
    logic        r_ovld;
    logic [16:0] r_score;
    logic [26:0] r_total;

    logic w_acc;
    logic w_score_go;
    logic w_zero_go;
    ifs_pkg::t_walk_ctl w_ctl;
    ifs_pkg::t_node     w_nd;
    logic               w_sc_valid;
    logic [16:0]        w_sc_score;
    logic [26:0]        w_sc_total;

    assign o_ready     = !r_busy && !r_ovld;
    assign o_cfg_ready = 1'b1;
    assign w_acc       = i_valid && o_ready;
    assign w_score_go  = w_acc && (i_cmd == ifs_pkg::CMD_FEAT) && i_final_element;
    assign w_zero_go   = w_score_go && (r_tree_count == 7'd0);
    assign w_ctl.start = w_score_go && (r_tree_count != 7'd0);

    always_comb begin
        w_nd.feat  = i_split_sel;
        w_nd.leaf  = i_leaf_flag;
        w_nd.split = i_data_value;
        w_nd.left  = i_lo_link;
        w_nd.right = i_hi_link;
        w_nd.adj   = i_leaf_adjust;
    end

    ifs_walker #(
        .NODE_DEPTH(NODE_DEPTH), .MAX_TREES(MAX_TREES),
        .MAX_FEATURES(MAX_FEATURES), .DEPTH_GUARD(DEPTH_GUARD)
    ) u_walk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_ctl.start),
        .i_tree_count(r_tree_count), .i_node_count(r_node_count),
        .i_feat_total(r_feat_total),
        .i_node_we(w_acc && i_cmd == ifs_pkg::CMD_NODE && 32'(i_slot) < NODE_DEPTH),
        .i_node_waddr(NAW'(i_slot)), .i_node_wdata(w_nd),
        .i_root_we(w_acc && i_cmd == ifs_pkg::CMD_ROOT && 32'(i_slot) < MAX_TREES),
        .i_root_waddr(TIW'(i_slot)), .i_root_wdata(i_hi_link),
        .i_feat_we(w_acc && i_cmd == ifs_pkg::CMD_FEAT && 32'(i_slot) < MAX_FEATURES),
        .i_feat_waddr(FIW'(i_slot)), .i_feat_wdata(i_data_value),
        .o_done(w_ctl.done), .o_sum(w_ctl.sum)
    );

    ifs_score u_score (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_go(w_ctl.done),
        .i_sum(w_ctl.sum), .i_scale(r_path_scale),
        .o_valid(w_sc_valid), .o_score(w_sc_score), .o_total(w_sc_total)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tree_count <= '0;
            r_node_count <= '0;
            r_feat_total <= '0;
            r_path_scale <= '0;
            r_busy       <= 1'b0;
            r_ovld       <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    ifs_pkg::REG_TREE_COUNT: r_tree_count <= i_cfg_data[6:0];
                    ifs_pkg::REG_NODE_COUNT: r_node_count <= i_cfg_data[15:0];
                    ifs_pkg::REG_FEAT_TOTAL: r_feat_total <= i_cfg_data[5:0];
                    ifs_pkg::REG_PATH_SCALE: r_path_scale <= i_cfg_data;
                    default: ;
                endcase
            end
            if (w_ctl.start) r_busy <= 1'b1;
            if (w_zero_go) begin
                r_ovld  <= 1'b1;
                r_score <= '0;
                r_total <= '0;
            end else if (w_sc_valid) begin
                r_busy  <= 1'b0;
                r_ovld  <= 1'b1;
                r_score <= w_sc_score;
                r_total <= w_sc_total;
            end else if (r_ovld && i_ready) begin
                r_ovld <= 1'b0;
            end
        end
    end

    assign o_valid    = r_ovld;
    assign o_score    = r_score;
    assign o_path_sum = r_total;

    // no new item while a result or a walk is pending
    a_no_acc_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy || r_ovld) |-> !o_ready) else $error("item taken while busy");
    // result holds until transferred
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_score)))
        else $error("result dropped");
    // score never above one
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_score <= 17'd65536)) else $error("score out of range");
endmodule
`default_nettype wire
